@@ sv/grbe_pkg.sv @@
// Package for the glyph row bit-plane expander: types, register codes and pixel functions.
`default_nettype none

package grbe_pkg;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_COLOUR_PAIR    = 3'd0;
  localparam logic [2:0] REG_DEEP_PIXELS    = 3'd1;
  localparam logic [2:0] REG_TEXT_HEIGHT    = 3'd2;
  localparam logic [2:0] REG_BYTES_PER_LINE = 3'd3;
  localparam logic [2:0] REG_WINDOW_LEFT    = 3'd4;
  localparam logic [2:0] REG_WINDOW_RIGHT   = 3'd5;
  localparam logic [2:0] REG_WINDOW_TOP     = 3'd6;
  localparam logic [2:0] REG_WINDOW_BOTTOM  = 3'd7;

  // Number of colour planes present.
  localparam logic [2:0] PLANE_COUNT = 3'd3;

  // Bounds of the character codes that are never drawn: every code below the first printable one, and delete.
  localparam logic [7:0] CHAR_FIRST_PRINT = 8'd32;
  localparam logic [7:0] CHAR_DELETE      = 8'd127;

  localparam logic [1:0] COUNT_FLAT = 2'd1;
  localparam logic [1:0] COUNT_DEEP = 2'd2;

  localparam int unsigned OFFSET_W = 17;
  localparam int unsigned LINE_W   = 11;

  typedef struct packed {
    logic [11:0] colour_pair;
    logic        deep_pixels;
    logic [4:0]  text_height;
    logic [7:0]  bytes_per_line;
    logic [6:0]  window_left;
    logic [6:0]  window_right;
    logic [5:0]  window_top;
    logic [5:0]  window_bottom;
  } cfg_t;

  // Load enables of the three pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } adv_t;

  // 64-colour mode: each nibble bit becomes a 2-bit pixel with the plane's fg or bg code.
  function automatic logic [7:0] deep_byte(input logic [3:0] nib, input logic [1:0] plane,
                                           input logic [11:0] colour);
    logic [5:0] fg;
    logic [5:0] bg;
    logic [1:0] fc;
    logic [1:0] bc;
    logic [7:0] px;
    fg = colour[5:0];
    bg = colour[11:6];
    fc = {fg[{1'b0, plane}], fg[{1'b0, plane} + 3'd3]};
    bc = {bg[{1'b0, plane}], bg[{1'b0, plane} + 3'd3]};
    for (int i = 0; i < 4; i++) begin
      px[2*i +: 2] = {2{nib[i]}};
    end
    return (px & {4{fc}}) | (~px & {4{bc}});
  endfunction

  // 8-colour mode: the row, its inverse, all ones or all zeros.
  function automatic logic [7:0] flat_byte(input logic [7:0] row, input logic [1:0] plane,
                                           input logic [11:0] colour);
    logic f;
    logic b;
    f = colour[{2'b00, plane}];
    b = colour[4'd6 + {2'b00, plane}];
    if (f == b) begin
      return {8{f}};
    end
    return f ? row : ~row;
  endfunction

endpackage

`default_nettype wire

@@ sv/glyph_row_bitplane_expand.sv @@
// An accepted input beat passes the three register stages to its output beat; a stall holds it.
// Throughput: one beat per cycle while the output is not stalled; the three register stages each hold one beat.
// Dropped rows (control codes, outside window, absent plane, line past height) leave no beat.
// Output stage is the last pipeline register; with a result waiting, input needs a free stage.
// Reset clears the valid bits and loads config defaults; the datapath registers are not reset.
`default_nettype none

module glyph_row_bitplane_expand #(
  parameter logic [2:0] PLANE_COUNT = grbe_pkg::PLANE_COUNT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // tdata: char_code[7:0], cell_column[14:8], cell_row[20:15], glyph_line[24:21],
  //        glyph_bits[32:25], zero fill [39:33]
  input  wire logic [39:0] s_axis_tdata_i,
  // tuser: plane_index[1:0]
  input  wire logic [1:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // tdata: byte_offset[16:0], first_byte[24:17], second_byte[32:25], byte_count[34:33],
  //        zero fill [39:35]
  output logic [39:0]      m_axis_tdata_o,
  // tuser: plane_out[1:0]
  output logic [1:0]       m_axis_tuser_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [11:0] cfg_data_i
);

  grbe_pkg::cfg_t cfg;
  grbe_pkg::adv_t adv;

  logic [7:0]  char_code;
  logic [6:0]  cell_column;
  logic [5:0]  cell_row;
  logic [3:0]  glyph_line;
  logic [7:0]  glyph_bits;
  logic [1:0]  plane_index;
  logic        keep;
  logic        v1_q;
  logic        v2_q;
  logic        v3_q;
  logic        v1_d;
  logic        v2_d;
  logic        v3_d;
  logic [16:0] byte_offset;
  logic [1:0]  plane_out;
  logic [7:0]  first_byte;
  logic [7:0]  second_byte;
  logic [1:0]  byte_count;

  assign char_code   = s_axis_tdata_i[7:0];
  assign cell_column = s_axis_tdata_i[14:8];
  assign cell_row    = s_axis_tdata_i[20:15];
  assign glyph_line  = s_axis_tdata_i[24:21];
  assign glyph_bits  = s_axis_tdata_i[32:25];
  assign plane_index = s_axis_tuser_i;

  grbe_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // A row is drawn only when every window and range check passes.
  assign keep = (char_code >= grbe_pkg::CHAR_FIRST_PRINT) &&
                (char_code != grbe_pkg::CHAR_DELETE) &&
                (cell_column >= cfg.window_left) && (cell_column <= cfg.window_right) &&
                (cell_row >= cfg.window_top) && (cell_row <= cfg.window_bottom) &&
                ({1'b0, plane_index} < PLANE_COUNT) &&
                ({1'b0, glyph_line} < cfg.text_height);

  // A stage loads when it is empty or the stage after it moves on.
  assign adv.s3 = !v3_q || m_axis_tready_i;
  assign adv.s2 = !v2_q || adv.s3;
  assign adv.s1 = !v1_q || adv.s2;

  assign s_axis_tready_o = adv.s1;

  assign v1_d = adv.s1 ? (s_axis_tvalid_i && keep) : v1_q;
  assign v2_d = adv.s2 ? v1_q : v2_q;
  assign v3_d = adv.s3 ? v2_q : v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  grbe_addr u_addr (
    .clk_i         (clk_i),
    .adv_i         (adv),
    .cfg_i         (cfg),
    .cell_column_i (cell_column),
    .cell_row_i    (cell_row),
    .glyph_line_i  (glyph_line),
    .byte_offset_o (byte_offset)
  );

  grbe_pix u_pix (
    .clk_i         (clk_i),
    .adv_i         (adv),
    .cfg_i         (cfg),
    .glyph_bits_i  (glyph_bits),
    .plane_index_i (plane_index),
    .plane_out_o   (plane_out),
    .first_byte_o  (first_byte),
    .second_byte_o (second_byte),
    .byte_count_o  (byte_count)
  );

  assign m_axis_tvalid_o = v3_q;
  assign m_axis_tdata_o  = {5'b00000, byte_count, second_byte, first_byte, byte_offset};
  assign m_axis_tuser_o  = plane_out;

endmodule

`default_nettype wire

@@ sv/grbe_cfg.sv @@
// Configuration register file of the glyph row bit-plane expander.
`default_nettype none

module grbe_cfg (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [11:0]        cfg_data_i,
  output grbe_pkg::cfg_t          cfg_o
);

  grbe_pkg::cfg_t cfg_q;
  grbe_pkg::cfg_t cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        grbe_pkg::REG_COLOUR_PAIR:    cfg_d.colour_pair    = cfg_data_i;
        grbe_pkg::REG_DEEP_PIXELS:    cfg_d.deep_pixels    = cfg_data_i[0];
        grbe_pkg::REG_TEXT_HEIGHT:    cfg_d.text_height    = cfg_data_i[4:0];
        grbe_pkg::REG_BYTES_PER_LINE: cfg_d.bytes_per_line = cfg_data_i[7:0];
        grbe_pkg::REG_WINDOW_LEFT:    cfg_d.window_left    = cfg_data_i[6:0];
        grbe_pkg::REG_WINDOW_RIGHT:   cfg_d.window_right   = cfg_data_i[6:0];
        grbe_pkg::REG_WINDOW_TOP:     cfg_d.window_top     = cfg_data_i[5:0];
        grbe_pkg::REG_WINDOW_BOTTOM:  cfg_d.window_bottom  = cfg_data_i[5:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.colour_pair    <= 12'd7;
      cfg_q.deep_pixels    <= 1'b0;
      cfg_q.text_height    <= 5'd8;
      cfg_q.bytes_per_line <= 8'd80;
      cfg_q.window_left    <= 7'd0;
      cfg_q.window_right   <= 7'd79;
      cfg_q.window_top     <= 6'd0;
      cfg_q.window_bottom  <= 6'd29;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/grbe_addr.sv @@
// Byte offset datapath: line index, line times pitch, then the column term.
`default_nettype none

module grbe_addr (
  input  wire logic                              clk_i,
  input  wire grbe_pkg::adv_t                    adv_i,
  input  wire grbe_pkg::cfg_t                    cfg_i,
  input  wire logic [6:0]                        cell_column_i,
  input  wire logic [5:0]                        cell_row_i,
  input  wire logic [3:0]                        glyph_line_i,
  output logic [grbe_pkg::OFFSET_W-1:0]          byte_offset_o
);

  localparam int unsigned LW = grbe_pkg::LINE_W;
  localparam int unsigned OW = grbe_pkg::OFFSET_W;

  logic [LW-1:0]  line_d;
  logic [LW-1:0]  line_q;
  logic [6:0]     col1_q;
  logic [18:0]    prod_d;
  logic [OW-1:0]  prod_q;
  logic [7:0]     colterm_d;
  logic [7:0]     colterm_q;
  logic [OW-1:0]  offset_d;
  logic [OW-1:0]  offset_q;

  // Pixel line number across the whole screen.
  assign line_d = LW'(cell_row_i) * LW'(cfg_i.text_height) + LW'(glyph_line_i);

  // Each cell is two bytes wide in 64-colour mode.
  assign prod_d    = line_q * cfg_i.bytes_per_line;
  assign colterm_d = cfg_i.deep_pixels ? {col1_q, 1'b0} : {1'b0, col1_q};
  assign offset_d  = prod_q + OW'(colterm_q);

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      line_q <= line_d;
      col1_q <= cell_column_i;
    end
    if (adv_i.s2) begin
      prod_q    <= prod_d[OW-1:0];
      colterm_q <= colterm_d;
    end
    if (adv_i.s3) begin
      offset_q <= offset_d;
    end
  end

  assign byte_offset_o = offset_q;

endmodule

`default_nettype wire

@@ sv/grbe_pix.sv @@
// Pixel datapath: expands the glyph row into one or two plane bytes.
`default_nettype none

module grbe_pix (
  input  wire logic           clk_i,
  input  wire grbe_pkg::adv_t adv_i,
  input  wire grbe_pkg::cfg_t cfg_i,
  input  wire logic [7:0]     glyph_bits_i,
  input  wire logic [1:0]     plane_index_i,
  output logic [1:0]          plane_out_o,
  output logic [7:0]          first_byte_o,
  output logic [7:0]          second_byte_o,
  output logic [1:0]          byte_count_o
);

  logic [7:0] bits1_q;
  logic [1:0] plane1_q;
  logic [1:0] plane2_q;
  logic [1:0] plane3_q;
  logic [7:0] first_d;
  logic [7:0] second_d;
  logic [1:0] count_d;
  logic [7:0] first_q;
  logic [7:0] second_q;
  logic [1:0] count_q;
  logic [7:0] first3_q;
  logic [7:0] second3_q;
  logic [1:0] count3_q;

  always_comb begin
    if (cfg_i.deep_pixels) begin
      first_d  = grbe_pkg::deep_byte(bits1_q[7:4], plane1_q, cfg_i.colour_pair);
      second_d = grbe_pkg::deep_byte(bits1_q[3:0], plane1_q, cfg_i.colour_pair);
      count_d  = grbe_pkg::COUNT_DEEP;
    end else begin
      first_d  = grbe_pkg::flat_byte(bits1_q, plane1_q, cfg_i.colour_pair);
      second_d = 8'h00;
      count_d  = grbe_pkg::COUNT_FLAT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      bits1_q  <= glyph_bits_i;
      plane1_q <= plane_index_i;
    end
    if (adv_i.s2) begin
      first_q  <= first_d;
      second_q <= second_d;
      count_q  <= count_d;
      plane2_q <= plane1_q;
    end
    if (adv_i.s3) begin
      first3_q  <= first_q;
      second3_q <= second_q;
      count3_q  <= count_q;
      plane3_q  <= plane2_q;
    end
  end

  assign plane_out_o   = plane3_q;
  assign first_byte_o  = first3_q;
  assign second_byte_o = second3_q;
  assign byte_count_o  = count3_q;

endmodule

`default_nettype wire

@@ sv/grbe_chk.sv @@
// Port-level checker for the glyph row bit-plane expander, bound to the top level.
`default_nettype none

module grbe_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [39:0] m_axis_tdata_o,
  input wire logic [1:0]  m_axis_tuser_o
);

  // A stalled output beat stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("output beat changed while stalled");

  // One-byte beats carry a zero second byte; two-byte beats are the only other kind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (m_axis_tdata_o[34:33] == grbe_pkg::COUNT_FLAT && m_axis_tdata_o[32:25] == 8'h00) ||
      (m_axis_tdata_o[34:33] == grbe_pkg::COUNT_DEEP))
    else $error("byte count and second byte disagree");

  // Only present planes are written.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ({1'b0, m_axis_tuser_o} < grbe_pkg::PLANE_COUNT))
    else $error("beat for an absent plane");

  // The fill bits above the packed fields stay clear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[39:35] == 5'b00000))
    else $error("fill bits set in output beat");

endmodule

bind glyph_row_bitplane_expand grbe_chk u_grbe_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire
